@@ sv/sptg_pkg.sv @@
// Shared constants, sine table and item types for the sine PWM tone generator.
package sptg_pkg;

    // Field widths of the stream items.
    localparam int CODE_BITS   = 16;
    localparam int LENGTH_BITS = 8;
    localparam int FIELD_BITS  = 16;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 40;

    // Counter width of the PWM timer (8 to 24 bits).
    localparam int     COUNT_BITS = 16;
    localparam longint COUNT_MASK = (longint'(1) << COUNT_BITS) - 1;

    // Number of waveform steps per cycle of the tone; a power of two from 16 to 256.
    localparam int WAVE_STEPS    = 64;
    localparam int WAVE_IDX_BITS = $clog2(WAVE_STEPS);

    // Sine table geometry: 64 entries of 7 bits, full scale 0x40.
    localparam int TABLE_DEPTH = 64;
    localparam int TABLE_BITS  = $clog2(TABLE_DEPTH);
    localparam int SAMPLE_BITS = 7;

    localparam logic [SAMPLE_BITS-1:0] WAVE_TABLE [0:TABLE_DEPTH-1] = '{
        7'h20, 7'h23, 7'h26, 7'h29, 7'h2c, 7'h2f, 7'h32, 7'h34,
        7'h37, 7'h39, 7'h3b, 7'h3c, 7'h3e, 7'h3f, 7'h3f, 7'h40,
        7'h40, 7'h40, 7'h3f, 7'h3f, 7'h3e, 7'h3c, 7'h3b, 7'h39,
        7'h37, 7'h34, 7'h32, 7'h2f, 7'h2c, 7'h29, 7'h26, 7'h23,
        7'h20, 7'h1d, 7'h1a, 7'h17, 7'h14, 7'h11, 7'h0e, 7'h0c,
        7'h09, 7'h07, 7'h05, 7'h04, 7'h02, 7'h01, 7'h01, 7'h00,
        7'h00, 7'h00, 7'h01, 7'h01, 7'h02, 7'h04, 7'h05, 7'h07,
        7'h09, 7'h0c, 7'h0e, 7'h11, 7'h14, 7'h17, 7'h1a, 7'h1d
    };

    // Period law: TOP = (22750000 - 12857 * (code - 1100)) / 10000.
    // Rewritten as (NUM_BASE - SLOPE * code) / 10000 with a positive base.
    localparam int PERIOD_BASE = 22750000;
    localparam int SLOPE       = 12857;
    localparam int CODE_OFFSET = 1100;
    localparam int SCALE       = 10000;
    localparam int NUM_BASE    = PERIOD_BASE + SLOPE * CODE_OFFSET;
    localparam int SLOPE_BITS  = $clog2(SLOPE + 1);
    localparam int PROD_BITS   = CODE_BITS + SLOPE_BITS;
    localparam int NUM_BITS    = $clog2(NUM_BASE + 1);

    // Division by 10000 is a shift by 4 and then a division by 625,
    // done as a reciprocal multiply with a single correction step.
    localparam int     PRE_SHIFT   = 4;
    localparam int     DIV_REST    = SCALE >> PRE_SHIFT;
    localparam int     X_BITS      = NUM_BITS - PRE_SHIFT;
    localparam int     RECIP_SHIFT = 32;
    localparam longint RECIP       = (longint'(1) << RECIP_SHIFT) / DIV_REST;
    localparam int     RECIP_BITS  = $clog2(RECIP + 1);
    localparam int     RPROD_BITS  = X_BITS + RECIP_BITS;
    localparam int     Q_BITS      = $clog2(((1 << X_BITS) - 1) / DIV_REST + 1);

    // Per-item control fields carried alongside the period computation.
    typedef struct packed {
        logic                   action;
        logic [LENGTH_BITS-1:0] note_length;
        logic                   centi_tick;
    } sptg_ctrl_t;

    // Item as seen by the voice stage: control fields plus the finished period.
    typedef struct packed {
        sptg_ctrl_t            ctrl;
        logic [COUNT_BITS-1:0] period;
    } sptg_note_t;

    // Result item.
    typedef struct packed {
        logic                  pwm_level;
        logic                  playing;
        logic [FIELD_BITS-1:0] period_top;
        logic [FIELD_BITS-1:0] duty_level;
    } sptg_result_t;

endpackage

@@ sv/sine_pwm_tone_generator_top.sv @@
// Top level of the sine PWM tone generator: stream unpacking, period pipeline and voice.
// A result item passes through period stages s1 to s4 and then the voice result register.
// Throughput: one item per cycle unless the result side stalls; the period pipeline and
// the voice state both take a new item every cycle, so the tone counter advances once
// per tick item. Back-pressure on the result side stalls the pipeline stage by stage.
// Reset (rst_n low, asynchronous) clears all valid bits and the tone state to silence.
module sine_pwm_tone_generator_top
    import sptg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // pitch_code [15:0], note_length [23:16], centi_tick [24], zero fill above
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // action [0]
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // pwm_level [0], playing [1], period_top [17:2], duty_level [33:18], zero fill above
    output logic [OUT_DATA_BITS-1:0] m_tdata
);

    sptg_ctrl_t           in_ctrl;
    logic [CODE_BITS-1:0] in_code;
    logic                 note_valid;
    logic                 note_ready;
    sptg_note_t           note;
    sptg_result_t         result;

    // Unpack the input item.
    always_comb
    begin
        in_code             = s_tdata[CODE_BITS-1:0];
        in_ctrl.action      = s_tuser;
        in_ctrl.note_length = s_tdata[CODE_BITS +: LENGTH_BITS];
        in_ctrl.centi_tick  = s_tdata[CODE_BITS + LENGTH_BITS];
    end

    sptg_period u_period (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_ctrl   (in_ctrl),
        .in_code   (in_code),
        .out_valid (note_valid),
        .out_ready (note_ready),
        .out_note  (note)
    );

    sptg_voice u_voice (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (note_valid),
        .in_ready   (note_ready),
        .in_note    (note),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the result item, first field lowest.
    assign m_tdata = OUT_DATA_BITS'({result.duty_level, result.period_top,
                                     result.playing, result.pwm_level});

endmodule

@@ sv/sptg_period.sv @@
// Pipelined conversion of a pitch code into a counter period.
module sptg_period
    import sptg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sptg_ctrl_t           in_ctrl,
    input  logic [CODE_BITS-1:0] in_code,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sptg_note_t           out_note
);

    // Stage registers.
    logic                  s1_valid_reg;
    sptg_ctrl_t            s1_ctrl_reg;
    logic [CODE_BITS-1:0]  s1_code_reg;

    logic                  s2_valid_reg;
    sptg_ctrl_t            s2_ctrl_reg;
    logic [PROD_BITS-1:0]  s2_prod_reg;
    logic [PROD_BITS-1:0]  s2_prod_next;

    logic                  s3_valid_reg;
    sptg_ctrl_t            s3_ctrl_reg;
    logic                  s3_pos_reg;
    logic                  s3_pos_next;
    logic [X_BITS-1:0]     s3_x_reg;
    logic [X_BITS-1:0]     s3_x_next;
    logic [Q_BITS-1:0]     s3_q0_reg;
    logic [Q_BITS-1:0]     s3_q0_next;

    logic                  s4_valid_reg;
    sptg_note_t            s4_note_reg;
    logic [COUNT_BITS-1:0] s4_period_next;

    logic                  s2_ready;
    logic                  s3_ready;
    logic                  s4_ready;

    logic [NUM_BITS-1:0]   num;
    logic [RPROD_BITS-1:0] recip_prod;
    logic [X_BITS-1:0]     back_prod;
    logic [X_BITS-1:0]     rem;
    logic [Q_BITS-1:0]     q_fixed;

    // Each stage moves on when it is empty or the stage after it moves.
    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = !s1_valid_reg || s2_ready;

    // Stage two: slope times code.
    assign s2_prod_next = PROD_BITS'(s1_code_reg) * PROD_BITS'(SLOPE);

    // Stage three: numerator, its sign and the estimated quotient by 625.
    always_comb
    begin
        num         = NUM_BITS'(PROD_BITS'(NUM_BASE) - s2_prod_reg);
        s3_pos_next = s2_prod_reg < PROD_BITS'(NUM_BASE);
        s3_x_next   = num[NUM_BITS-1:PRE_SHIFT];
        recip_prod  = RPROD_BITS'(s3_x_next) * RPROD_BITS'(RECIP);
        s3_q0_next  = recip_prod[RECIP_SHIFT +: Q_BITS];
    end

    // Stage four: correct the estimate by one and clamp to the counter range.
    always_comb
    begin
        back_prod = X_BITS'(s3_q0_reg) * X_BITS'(DIV_REST);
        rem       = s3_x_reg - back_prod;
        q_fixed   = (rem >= X_BITS'(DIV_REST)) ? s3_q0_reg + Q_BITS'(1) : s3_q0_reg;
        if (!s3_pos_reg)
        begin
            s4_period_next = '0;
        end
        else if (64'(q_fixed) > 64'(COUNT_MASK))
        begin
            s4_period_next = COUNT_BITS'(COUNT_MASK);
        end
        else
        begin
            s4_period_next = COUNT_BITS'(q_fixed);
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload of the pipeline.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_ctrl_reg <= in_ctrl;
            s1_code_reg <= in_code;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
            s2_prod_reg <= s2_prod_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_ctrl_reg <= s2_ctrl_reg;
            s3_pos_reg  <= s3_pos_next;
            s3_x_reg    <= s3_x_next;
            s3_q0_reg   <= s3_q0_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_note_reg.ctrl   <= s3_ctrl_reg;
            s4_note_reg.period <= s4_period_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_note  = s4_note_reg;

endmodule

@@ sv/sptg_voice.sv @@
// Tone state: PWM counter, sine duty update, note timing and result register.
module sptg_voice
    import sptg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  sptg_note_t   in_note,
    output logic         out_valid,
    input  logic         out_ready,
    output sptg_result_t out_result
);

    logic [COUNT_BITS-1:0]  tick_count_reg;
    logic [COUNT_BITS-1:0]  tick_count_next;
    logic [COUNT_BITS-1:0]  top_value_reg;
    logic [COUNT_BITS-1:0]  top_value_next;
    logic [COUNT_BITS-1:0]  duty_value_reg;
    logic [COUNT_BITS-1:0]  duty_value_next;
    logic [WAVE_IDX_BITS-1:0] wave_index_reg;
    logic [WAVE_IDX_BITS-1:0] wave_index_next;
    logic [LENGTH_BITS-1:0] elapsed_reg;
    logic [LENGTH_BITS-1:0] elapsed_next;
    logic [LENGTH_BITS-1:0] length_reg;
    logic [LENGTH_BITS-1:0] length_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic                   res_valid_reg;
    sptg_result_t           result_reg;
    sptg_result_t           result_next;

    logic                   accept;
    logic                   wrap;
    logic [COUNT_BITS-1:0]  tick_inc;
    logic [WAVE_IDX_BITS+TABLE_BITS-1:0] scaled_index;
    logic [TABLE_BITS-1:0]  table_index;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS+COUNT_BITS-1:0] duty_prod;
    logic [COUNT_BITS-1:0]  duty_wrap;
    logic [LENGTH_BITS-1:0] elapsed_inc;
    logic                   pwm_next;

    // The result register frees up as soon as its item is taken.
    assign in_ready = !res_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Wrap detection and the sine-scaled duty for the next period.
    always_comb
    begin
        wrap         = tick_count_reg >= top_value_reg;
        tick_inc     = tick_count_reg + COUNT_BITS'(1);
        scaled_index = {wave_index_reg, TABLE_BITS'(0)};
        table_index  = scaled_index[WAVE_IDX_BITS +: TABLE_BITS];
        sample       = WAVE_TABLE[table_index];
        duty_prod    = (SAMPLE_BITS + COUNT_BITS)'(sample)
                     * (SAMPLE_BITS + COUNT_BITS)'(top_value_reg);
        duty_wrap    = COUNT_BITS'(duty_prod >> TABLE_BITS);
        elapsed_inc  = (elapsed_reg < length_reg) ? elapsed_reg + LENGTH_BITS'(1)
                                                  : elapsed_reg;
    end

    // Next state for one item.
    always_comb
    begin
        tick_count_next = tick_count_reg;
        top_value_next  = top_value_reg;
        duty_value_next = duty_value_reg;
        wave_index_next = wave_index_reg;
        elapsed_next    = elapsed_reg;
        length_next     = length_reg;
        busy_next       = busy_reg;
        pwm_next        = tick_count_reg >= duty_value_reg;

        if (in_note.ctrl.action)
        begin
            // A note replaces period and length; elapsed time carries on.
            top_value_next = in_note.period;
            length_next    = in_note.ctrl.note_length;
            busy_next      = 1'b1;
        end
        else
        begin
            if (wrap)
            begin
                tick_count_next = '0;
                duty_value_next = duty_wrap;
                wave_index_next = wave_index_reg + WAVE_IDX_BITS'(1);
                pwm_next        = (duty_wrap == '0);
            end
            else
            begin
                tick_count_next = tick_inc;
                pwm_next        = tick_inc >= duty_value_reg;
            end

            // Note timing runs after the counter update of the same tick.
            if (in_note.ctrl.centi_tick && busy_reg)
            begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc >= length_reg)
                begin
                    top_value_next = '0;
                    elapsed_next   = '0;
                    busy_next      = 1'b0;
                end
            end
        end

        result_next.pwm_level  = pwm_next;
        result_next.playing    = busy_next;
        result_next.period_top = FIELD_BITS'(top_value_next);
        result_next.duty_level = FIELD_BITS'(duty_value_next);
    end

    // Tone state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            top_value_reg  <= '0;
            duty_value_reg <= '0;
            wave_index_reg <= '0;
            elapsed_reg    <= '0;
            length_reg     <= '0;
            busy_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                tick_count_reg <= tick_count_next;
                top_value_reg  <= top_value_next;
                duty_value_reg <= duty_value_next;
                wave_index_reg <= wave_index_next;
                elapsed_reg    <= elapsed_next;
                length_reg     <= length_next;
                busy_reg       <= busy_next;
            end
            if (in_ready)
            begin
                res_valid_reg <= in_valid;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = res_valid_reg;
    assign out_result = result_reg;

    // A note only ends on a tick item that closes a 10 ms interval.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(accept && !in_note.ctrl.action && in_note.ctrl.centi_tick))
        else $error("note ended without a 10 ms tick");

    // The end of a note silences the counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> top_value_reg == '0)
        else $error("period not cleared at end of note");

    // With a silent period every tick wraps, so the counter stays at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_note.ctrl.action && top_value_reg == '0 |=> tick_count_reg == '0)
        else $error("counter ran with a silent period");

    // Every accepted item leaves a result that reports the updated note state.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg && result_reg.playing == busy_reg)
        else $error("result does not match note state");

endmodule

@@ test/sine_pwm_tone_generator_checker.sv @@
// Action codes for the tone generator stream, and the checker that predicts and compares each result item.
package sptg_tb_pkg;

    // What an input item means, carried on s_tuser.
    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_NOTE = 1'b1
    } sptg_action_e;

endpackage

module sine_pwm_tone_generator_checker
    import sptg_pkg::*;
    import sptg_tb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    // pitch_code [15:0], note_length [23:16], centi_tick [24], zero fill above
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // action [0]
    input  logic                     s_tuser,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    // pwm_level [0], playing [1], period_top [17:2], duty_level [33:18], zero fill above
    input  logic [OUT_DATA_BITS-1:0] m_tdata,
    output int                       error_count,
    output int                       outstanding
);

    // The sine table is full scale at 0x40, so the scaled duty drops six bits.
    localparam int TABLE_SCALE_SHIFT = 6;

    // Bit positions of the result fields within m_tdata.
    localparam int PWM_POS  = 0;
    localparam int PLAY_POS = 1;
    localparam int TOP_POS  = 2;
    localparam int DUTY_POS = TOP_POS + FIELD_BITS;

    // Own copy of the voice state.
    logic [COUNT_BITS-1:0]    tone_count;
    logic [COUNT_BITS-1:0]    tone_top;
    logic [COUNT_BITS-1:0]    tone_duty;
    logic [WAVE_IDX_BITS-1:0] wave_pos;
    logic [LENGTH_BITS-1:0]   elapsed_units;
    logic [LENGTH_BITS-1:0]   length_units;
    logic                     busy;

    // Tone results still owed by the block, oldest first.
    sptg_result_t expected_tones [$];
    int           fails;

    // Counter top from a pitch code: exact integer law, truncated toward zero, then clamped.
    function automatic logic [COUNT_BITS-1:0] pitch_to_period(input logic [CODE_BITS-1:0] code);
        longint numer;
        longint quot;
        numer = longint'(PERIOD_BASE) - longint'(SLOPE) * (longint'(code) - CODE_OFFSET);
        quot  = numer / SCALE;
        if (quot < 0)
            return '0;
        if (quot > COUNT_MASK)
            return {COUNT_BITS{1'b1}};
        return quot[COUNT_BITS-1:0];
    endfunction

    // Applies one input item to the voice state and returns the state it leaves.
    task automatic advance_tone(
        input  logic                   is_note,
        input  logic [CODE_BITS-1:0]   code,
        input  logic [LENGTH_BITS-1:0] len,
        input  logic                   centi,
        output sptg_result_t           res
    );
        int                                k;
        logic [COUNT_BITS+SAMPLE_BITS-1:0] scaled;
        if (is_note == ACT_NOTE)
        begin
            tone_top     = pitch_to_period(code);
            length_units = len;
            busy         = 1'b1;
        end
        else
        begin
            // Counter wraps at the top and reloads the duty from the sine table.
            if (tone_count >= tone_top)
            begin
                k          = (int'(wave_pos) * TABLE_DEPTH / WAVE_STEPS) % TABLE_DEPTH;
                scaled     = (COUNT_BITS + SAMPLE_BITS)'(WAVE_TABLE[k])
                           * (COUNT_BITS + SAMPLE_BITS)'(tone_top);
                tone_count = '0;
                tone_duty  = COUNT_BITS'(scaled >> TABLE_SCALE_SHIFT);
                wave_pos   = WAVE_IDX_BITS'((int'(wave_pos) + 1) % WAVE_STEPS);
            end
            else
            begin
                tone_count = tone_count + 1'b1;
            end

            // Note timing runs after the counter update, and only while a note plays.
            if (centi && busy)
            begin
                if (elapsed_units < length_units)
                    elapsed_units = elapsed_units + 1'b1;
                if (elapsed_units >= length_units)
                begin
                    tone_top      = '0;
                    elapsed_units = '0;
                    busy          = 1'b0;
                end
            end
        end
        res.pwm_level  = (tone_count >= tone_duty);
        res.playing    = busy;
        res.period_top = FIELD_BITS'(tone_top);
        res.duty_level = FIELD_BITS'(tone_duty);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endtask

    // Watch both channels: predict on every accepted input item, compare on every result item.
    always @(posedge clk or negedge rst_n)
    begin : tone_monitor
        sptg_result_t predicted;
        sptg_result_t wanted;
        if (!rst_n)
        begin
            tone_count    = '0;
            tone_top      = '0;
            tone_duty     = '0;
            wave_pos      = '0;
            elapsed_units = '0;
            length_units  = '0;
            busy          = 1'b0;
            fails         = 0;
            expected_tones.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_tone(s_tuser, s_tdata[CODE_BITS-1:0],
                             s_tdata[CODE_BITS +: LENGTH_BITS],
                             s_tdata[CODE_BITS+LENGTH_BITS], predicted);
                expected_tones.push_back(predicted);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_tones.size() == 0)
                begin
                    $display("%0t: result item with none expected, got %h", $time, m_tdata);
                    fails++;
                end
                else
                begin
                    wanted = expected_tones.pop_front();
                    compare_field("pwm_level", 32'(wanted.pwm_level), 32'(m_tdata[PWM_POS]));
                    compare_field("playing", 32'(wanted.playing), 32'(m_tdata[PLAY_POS]));
                    compare_field("period_top", 32'(wanted.period_top),
                                  32'(m_tdata[TOP_POS +: FIELD_BITS]));
                    compare_field("duty_level", 32'(wanted.duty_level),
                                  32'(m_tdata[DUTY_POS +: FIELD_BITS]));
                end
            end
        end
        error_count <= fails;
        outstanding <= expected_tones.size();
    end

endmodule

@@ test/sine_pwm_tone_generator_top_tb.sv @@
// Testbench top for the sine PWM tone generator: clock, reset, item stimulus, flow control and verdict.
module sine_pwm_tone_generator_top_tb;
    import sptg_pkg::*;
    import sptg_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;

    int error_count;
    int outstanding;
    int items_sent  = 0;
    int quiet_count = 0;
    int ready_hold  = 0;
    bit steady      = 1'b0;

    sine_pwm_tone_generator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sine_pwm_tone_generator_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    // Stall lengths: mostly short stalls, now and then a long one.
    function automatic int stall_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Pitch codes: mostly near the short periods, plus the whole range and the corners.
    function automatic logic [CODE_BITS-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return CODE_BITS'($urandom_range(2780, 2880));
        if (r < 70)
            return CODE_BITS'($urandom_range(0, 65535));
        if (r < 85)
            return CODE_BITS'($urandom_range(0, 2900));
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'd1100;
            3:       return 16'd2868;
            4:       return 16'd2869;
            default: return 16'd2870;
        endcase
    endfunction

    // Note lengths: mostly short so that notes end often.
    function automatic logic [LENGTH_BITS-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return LENGTH_BITS'($urandom_range(0, 4));
        if (r < 95)
            return LENGTH_BITS'($urandom_range(0, 255));
        return {LENGTH_BITS{1'b1}};
    endfunction

    // Offers one item after a random gap and waits until the block takes it.
    task automatic send_item(input sptg_action_e act, input logic [CODE_BITS-1:0] code,
                             input logic [LENGTH_BITS-1:0] len, input logic centi);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 60) ? 0 : stall_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= IN_DATA_BITS'({centi, len, code});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Tick items carry random note fields, which the block must ignore.
    task automatic tick(input logic centi);
        send_item(ACT_TICK, CODE_BITS'($urandom), LENGTH_BITS'($urandom), centi);
    endtask

    // Note items carry a random centi_tick, which the block must ignore.
    task automatic play(input logic [CODE_BITS-1:0] code, input logic [LENGTH_BITS-1:0] len);
        send_item(ACT_NOTE, code, len, 1'($urandom_range(0, 1)));
    endtask

    // Result side: random stalls, or always ready during a steady stretch.
    always @(posedge clk)
    begin
        if (steady)
        begin
            m_tready <= 1'b1;
            ready_hold = 0;
        end
        else if (ready_hold > 0)
        begin
            ready_hold--;
        end
        else if (m_tready)
        begin
            m_tready <= 1'b0;
            ready_hold = stall_length() - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 20);
        end
    end

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int run_end;
        int n;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_TICK;
        m_tready <= 1'b0;
        rst_n    <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Time ticks while idle are ignored.
        tick(1'b1);
        tick(1'b1);
        // Highest code and longest note: silent period, every tick wraps.
        play(16'hffff, 8'hff);
        tick(1'b0);
        tick(1'b0);
        // Lowest code gives the longest period; a zero length ends on the first time tick.
        play(16'd0, 8'd0);
        tick(1'b0);
        tick(1'b1);
        // Short period, let the counter climb, then a shorter period below the count.
        play(16'd2860, 8'd3);
        repeat (6) tick(1'b0);
        play(16'd2868, 8'd3);
        tick(1'b0);
        repeat (3) tick(1'b1);
        // Centre code, then a new note while busy keeps the elapsed time.
        play(16'd1100, 8'd2);
        tick(1'b1);
        play(16'd2869, 8'd5);
        tick(1'b1);

        // Random phrases: a note, then a run of ticks with the odd note cutting in.
        run_end = items_sent + RANDOM_ITEMS;
        while (items_sent < run_end)
        begin
            if ($urandom_range(0, 9) == 0)
                steady = ~steady;
            play(pick_code(), pick_length());
            n = $urandom_range(4, 60);
            repeat (n)
            begin
                if ($urandom_range(0, 39) == 0)
                    play(pick_code(), pick_length());
                else
                    tick($urandom_range(0, 3) == 0);
            end
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        // Drain the results still owed, then allow for stray items.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
